// ===== src/fos_pkg.sv =====
// Shared types and constants for the framed operand stack.
// Used by fos_cell and framed_operand_stack_unit; no dependencies.
package fos_pkg;

  localparam int OPCODE_W    = 3;
  localparam int IN_VALUE_W  = 32;
  localparam int PEEK_W      = 8;
  localparam int OUT_VALUE_W = 32;
  localparam int STATUS_W    = 3;
  localparam int COUNT_W     = 9;

  localparam int STORE_DEPTH_DEF = 256;
  localparam int MAX_FRAMES_DEF  = 16;
  localparam int VALUE_WIDTH_DEF = 32;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH     = 3'd0,
    OP_POP      = 3'd1,
    OP_PEEK     = 3'd2,
    OP_SWAP     = 3'd3,
    OP_ROT3     = 3'd4,
    OP_NEWLEVEL = 3'd5,
    OP_POPLEVEL = 3'd6
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK             = 3'd0,
    ST_UNDERFLOW      = 3'd1,
    ST_STORE_OVERFLOW = 3'd2,
    ST_PEEK_OOB       = 3'd3,
    ST_FRAME_OVERFLOW = 3'd4
  } status_t;

  // Command broadcast along a chain of cells.
  typedef enum logic [2:0] {
    CELL_HOLD = 3'd0,
    CELL_PUSH = 3'd1,
    CELL_POP  = 3'd2,
    CELL_SWAP = 3'd3,
    CELL_ROT  = 3'd4
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [PEEK_W-1:0] depth;
  } cell_cmd_t;

endpackage

// ===== src/fos_cell.sv =====
// One stack cell: holds one entry, shifts with its neighbors, taps out on a depth match.
// Depends on fos_pkg.
module fos_cell #(
  parameter int W   = 32,
  parameter int POS = 0
) (
  input  logic              clk,
  input  fos_pkg::cell_cmd_t cmd_i,
  input  logic [W-1:0]      up_i,
  input  logic [W-1:0]      down_i,
  input  logic [W-1:0]      up2_i,
  input  logic [W-1:0]      down2_i,
  output logic [W-1:0]      val_o,
  output logic [W-1:0]      rd_o
);
  import fos_pkg::*;

  localparam bit REACHABLE = POS < (2 ** PEEK_W);

  logic [W-1:0] val_r;
  logic [W-1:0] val_nxt;
  logic         match;

  always_comb begin
    val_nxt = val_r;
    unique case (cmd_i.op)
      CELL_HOLD: val_nxt = val_r;
      CELL_PUSH: val_nxt = up_i;
      CELL_POP:  val_nxt = down_i;
      CELL_SWAP: begin
        if (POS == 0) val_nxt = down_i;
        else if (POS == 1) val_nxt = up_i;
      end
      CELL_ROT: begin
        // top three reversed: only the outer two move
        if (POS == 0) val_nxt = down2_i;
        else if (POS == 2) val_nxt = up2_i;
      end
      default: val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign match = REACHABLE && (cmd_i.depth == PEEK_W'(POS));
  assign val_o = val_r;
  assign rd_o  = match ? val_r : '0;

endmodule

// ===== src/framed_operand_stack_unit.sv =====
// Top level of the framed operand stack: value chain, frame base chain, control.
// Depends on fos_pkg and fos_cell.
//
//  port group  | dir  | handshake             | payload
//  in_*        | in   | in_valid / in_ready   | in_opcode, in_push_value, in_peek_depth
//  out_*       | out  | out_valid / out_ready | out_read_value, out_status, out_frame_count
//
// Top of stack sits in cell 0; push and pop shift the whole chain by one each way.
// Every request is latched, then executed into the output register.
// Drop frame then drains the dropped frame's entries: the chain pops one a cycle.
// Execute waits while the output register holds an untaken result.
// Synchronous active-low reset clears pointers, frame level and valid; stored entries are not.
module framed_operand_stack_unit #(
  parameter int STORE_DEPTH = fos_pkg::STORE_DEPTH_DEF,
  parameter int MAX_FRAMES  = fos_pkg::MAX_FRAMES_DEF,
  parameter int VALUE_WIDTH = fos_pkg::VALUE_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [fos_pkg::OPCODE_W-1:0]    in_opcode,
  input  logic [fos_pkg::IN_VALUE_W-1:0]  in_push_value,
  input  logic [fos_pkg::PEEK_W-1:0]      in_peek_depth,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [fos_pkg::OUT_VALUE_W-1:0] out_read_value,
  output logic [fos_pkg::STATUS_W-1:0]    out_status,
  output logic [fos_pkg::COUNT_W-1:0]     out_frame_count
);
  import fos_pkg::*;

  localparam int TW    = $clog2(STORE_DEPTH + 1);
  localparam int LW    = $clog2(MAX_FRAMES + 1);
  localparam int CMP_W = (TW > PEEK_W) ? TW : PEEK_W;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_EXEC  = 3'b010,
    S_DRAIN = 3'b100
  } state_t;

  state_t                   state_r, state_nxt;
  opcode_t                  op_r;
  logic [VALUE_WIDTH-1:0]   val_r;
  logic [PEEK_W-1:0]        depth_r;
  logic [TW-1:0]            top_r, top_nxt;
  logic [TW-1:0]            base_r, base_nxt;
  logic [LW-1:0]            level_r, level_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [OUT_VALUE_W-1:0]   read_r, read_nxt;
  status_t                  status_r, status_nxt;
  logic [COUNT_W-1:0]       count_r, count_nxt;

  cell_cmd_t                vcmd, bcmd;
  logic [VALUE_WIDTH-1:0]   vval [STORE_DEPTH];
  logic [VALUE_WIDTH-1:0]   vrd  [STORE_DEPTH];
  logic [TW-1:0]            bval [MAX_FRAMES];
  logic [VALUE_WIDTH-1:0]   peek_val;
  logic [TW-1:0]            saved_base;
  logic [TW-1:0]            count;
  logic                     fire;

  // ---------------- value chain ----------------
  genvar gi;
  generate
    for (gi = 0; gi < STORE_DEPTH; gi++) begin : g_val
      logic [VALUE_WIDTH-1:0] up_w, down_w, up2_w, down2_w;
      if (gi == 0) begin : g_up0
        assign up_w  = val_r;
        assign up2_w = '0;
      end else if (gi == 1) begin : g_up1
        assign up_w  = vval[gi-1];
        assign up2_w = '0;
      end else begin : g_upn
        assign up_w  = vval[gi-1];
        assign up2_w = vval[gi-2];
      end
      if (gi + 1 < STORE_DEPTH) begin : g_dn
        assign down_w = vval[gi+1];
      end else begin : g_dn_end
        assign down_w = '0;
      end
      if (gi + 2 < STORE_DEPTH) begin : g_dn2
        assign down2_w = vval[gi+2];
      end else begin : g_dn2_end
        assign down2_w = '0;
      end
      fos_cell #(.W(VALUE_WIDTH), .POS(gi)) u_cell (
        .clk     (clk),
        .cmd_i   (vcmd),
        .up_i    (up_w),
        .down_i  (down_w),
        .up2_i   (up2_w),
        .down2_i (down2_w),
        .val_o   (vval[gi]),
        .rd_o    (vrd[gi])
      );
    end

    // ---------------- saved frame base chain ----------------
    for (gi = 0; gi < MAX_FRAMES; gi++) begin : g_base
      logic [TW-1:0] up_w, down_w;
      if (gi == 0) begin : g_up0
        assign up_w = base_r;
      end else begin : g_upn
        assign up_w = bval[gi-1];
      end
      if (gi + 1 < MAX_FRAMES) begin : g_dn
        assign down_w = bval[gi+1];
      end else begin : g_dn_end
        assign down_w = '0;
      end
      fos_cell #(.W(TW), .POS(gi)) u_cell (
        .clk     (clk),
        .cmd_i   (bcmd),
        .up_i    (up_w),
        .down_i  (down_w),
        .up2_i   ('0),
        .down2_i ('0),
        .val_o   (bval[gi]),
        .rd_o    ()
      );
    end
  endgenerate

  // only the matching cell drives a nonzero tap
  always_comb begin
    peek_val = '0;
    for (int i = 0; i < STORE_DEPTH; i++) begin
      peek_val = peek_val | vrd[i];
    end
  end

  assign saved_base = bval[0];
  assign count      = top_r - base_r;
  assign fire       = (state_r == S_EXEC) && (!out_valid_r || out_ready);

  // ---------------- control ----------------
  always_comb begin
    state_nxt     = state_r;
    top_nxt       = top_r;
    base_nxt      = base_r;
    level_nxt     = level_r;
    out_valid_nxt = out_valid_r && !out_ready;
    read_nxt      = read_r;
    status_nxt    = status_r;
    count_nxt     = count_r;
    vcmd.op       = CELL_HOLD;
    vcmd.depth    = depth_r;
    bcmd.op       = CELL_HOLD;
    bcmd.depth    = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (fire) begin
          state_nxt  = S_IDLE;
          read_nxt   = '0;
          status_nxt = ST_OK;
          unique case (op_r)
            OP_PUSH: begin
              if (top_r == TW'(STORE_DEPTH)) begin
                status_nxt = ST_STORE_OVERFLOW;
              end else begin
                vcmd.op = CELL_PUSH;
                top_nxt = top_r + TW'(1);
              end
            end
            OP_POP: begin
              if (count == '0) begin
                status_nxt = ST_UNDERFLOW;
              end else begin
                vcmd.op  = CELL_POP;
                top_nxt  = top_r - TW'(1);
                read_nxt = OUT_VALUE_W'(vval[0]);
              end
            end
            OP_PEEK: begin
              if (CMP_W'(depth_r) >= CMP_W'(count)) begin
                status_nxt = ST_PEEK_OOB;
              end else begin
                read_nxt = OUT_VALUE_W'(peek_val);
              end
            end
            OP_SWAP: begin
              if (count < TW'(2)) status_nxt = ST_UNDERFLOW;
              else vcmd.op = CELL_SWAP;
            end
            OP_ROT3: begin
              if (count < TW'(3)) status_nxt = ST_UNDERFLOW;
              else vcmd.op = CELL_ROT;
            end
            OP_NEWLEVEL: begin
              if (level_r == LW'(MAX_FRAMES)) begin
                status_nxt = ST_FRAME_OVERFLOW;
              end else begin
                bcmd.op   = CELL_PUSH;
                level_nxt = level_r + LW'(1);
                base_nxt  = top_r;
              end
            end
            OP_POPLEVEL: begin
              if (level_r != '0) begin
                state_nxt = S_DRAIN;
              end
            end
            default: ;
          endcase
          out_valid_nxt = 1'b1;
          // result count is known up front for drop frame
          if (op_r == OP_POPLEVEL && level_r != '0) begin
            count_nxt = COUNT_W'(base_r - saved_base);
          end else begin
            count_nxt = COUNT_W'(top_nxt - base_nxt);
          end
        end
      end
      S_DRAIN: begin
        if (top_r != base_r) begin
          vcmd.op = CELL_POP;
          top_nxt = top_r - TW'(1);
        end else begin
          bcmd.op   = CELL_POP;
          base_nxt  = saved_base;
          level_nxt = level_r - LW'(1);
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      top_r       <= '0;
      base_r      <= '0;
      level_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      top_r       <= top_nxt;
      base_r      <= base_nxt;
      level_r     <= level_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r    <= opcode_t'(in_opcode);
      val_r   <= VALUE_WIDTH'(in_push_value);
      depth_r <= in_peek_depth;
    end
    read_r   <= read_nxt;
    status_r <= status_nxt;
    count_r  <= count_nxt;
  end

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_read_value  = read_r;
  assign out_status      = status_r;
  assign out_frame_count = count_r;

endmodule
